// ===== hdl/cbfqs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfqs_pkg: shared types and constants for the credit-based fair queue
// scheduler. Holds the item structs, the sequencer states, the register
// indexes, the register reset values and the credit limits.
// ----------------------------------------------------------------------------
package cbfqs_pkg;

  // Default sizes handed to the top level parameters.
  localparam int NUM_QUEUES_DEF  = 5;
  localparam int QUEUE_DEPTH_DEF = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_CREDIT_GAIN  = 2'd0;
  localparam logic [1:0] CFG_SERVICE_COST = 2'd1;
  localparam logic [1:0] CFG_QUEUE_LIMIT  = 2'd2;

  // Register reset values.
  localparam logic [15:0] CREDIT_GAIN_RST  = 16'd66;
  localparam logic [23:0] SERVICE_COST_RST = 24'd65536;
  localparam logic [5:0]  QUEUE_LIMIT_RST  = 6'd20;

  // Item operation codes.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // Credit limits, Q.16 signed.
  localparam logic signed [31:0] CREDIT_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CREDIT_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] SERVE_FLOOR = -32'sd65536;

  // Input item.
  typedef struct packed {
    logic        opcode;
    logic [15:0] packet_size;
    logic [7:0]  flow_number;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic               accepted;
    logic               served_valid;
    logic [2:0]         served_queue;
    logic [15:0]        served_size;
    logic [7:0]         served_flow;
    logic signed [31:0] served_credit;
    logic               all_empty;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT,
    S_REM,
    S_CREDIT,
    S_SCAN,
    S_DSCAN,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ===== hdl/cbfqs_ram.sv =====
// ----------------------------------------------------------------------------
// cbfqs_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbfqs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/credit_based_fair_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// credit_based_fair_queue_scheduler_core: credit-based fair queue scheduler
// Keeps one packet ring per queue with a signed Q.16 credit and picks the
// packet to serve with a small sequencer around one shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid/in_stall/in_item. An arrive item charges
//   credit to queue flow_number mod NUM_QUEUES, enqueues the packet if there
//   is room and serves the best queue; a drain item serves the lowest
//   non-empty queue. Each item gives exactly one result item on
//   out_valid/out_stall/out_item.
//   Steps: an arrive item passes S_QUOT, S_REM, S_CREDIT and the credit
//   scan S_SCAN, then S_READ if a packet is served, to the result register;
//   a drain item passes S_DSCAN, then S_READ if a queue is non-empty. The
//   sequencer returns to S_IDLE before the next item is taken. The credit
//   scan visits one queue per cycle through the shared adder.
//   in_stall is high while an item is being worked on.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls and the register is still full when the
//   following result is ready, the sequencer holds until it is taken.
//   Configuration registers are written through cfg_write/cfg_index/cfg_data;
//   the user must write them only while the block is idle (not enforced).
//   Reset (rst, synchronous) empties all queues, clears the credits and
//   restores the register defaults; the packet store itself is not cleared.
// ----------------------------------------------------------------------------
module credit_based_fair_queue_scheduler_core #(
  parameter int NUM_QUEUES  = cbfqs_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = cbfqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cbfqs_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cbfqs_pkg::out_item_t out_item,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data
);

  localparam int QW     = $clog2(NUM_QUEUES);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W  = (OCC_W > 6) ? OCC_W : 6;
  localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int RECIP  = (65536 + NUM_QUEUES - 1) / NUM_QUEUES;

  // Configuration registers.
  logic [15:0] credit_gain;
  logic [23:0] service_cost;
  logic [5:0]  queue_limit;

  // Per-queue state.
  logic [PTR_W-1:0]   head [NUM_QUEUES];
  logic [OCC_W-1:0]   occ [NUM_QUEUES];
  logic signed [31:0] credit [NUM_QUEUES];

  // Sequencer and working registers.
  cbfqs_pkg::state_t  state, state_next;
  logic [QW-1:0]      idx;
  logic [QW-1:0]      best;
  logic               found;
  logic signed [31:0] best_credit;
  logic               cur_opcode;
  logic [15:0]        cur_size;
  logic [7:0]         cur_flow;
  logic [7:0]         quot;
  logic               res_accepted;
  logic               res_served;
  logic signed [31:0] res_credit;

  // Values of the queue under the index.
  logic [PTR_W-1:0]   head_cur;
  logic [OCC_W-1:0]   occ_cur;
  logic signed [31:0] credit_cur;
  assign head_cur   = head[idx];
  assign occ_cur    = occ[idx];
  assign credit_cur = credit[idx];

  // Shared adder with saturation.
  logic [31:0]        alu_b;
  logic               alu_sub;
  logic [33:0]        alu_sum;
  logic signed [31:0] alu_sat;
  logic               alu_gt;
  logic [QW:0]        weight;
  logic [QW+16:0]     weighted_gain;

  assign weight        = {1'b0, idx} + (QW+1)'(1);
  assign weighted_gain = (QW+17)'(weight) * (QW+17)'(credit_gain);

  // Operand selection for the shared adder.
  always_comb begin
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      cbfqs_pkg::S_CREDIT: alu_b = 32'(weighted_gain);
      cbfqs_pkg::S_SCAN: begin
        alu_b   = best_credit;
        alu_sub = 1'b1;
      end
      cbfqs_pkg::S_READ: begin
        alu_b   = 32'(service_cost);
        alu_sub = 1'b1;
      end
      default: alu_b = '0;
    endcase
  end

  always_comb begin
    logic [33:0] a_ext;
    logic [33:0] b_ext;
    a_ext   = {{2{credit_cur[31]}}, credit_cur};
    b_ext   = {{2{alu_b[31]}}, alu_b};
    alu_sum = a_ext + (alu_sub ? ~b_ext : b_ext) + 34'(alu_sub);
    if (alu_sum[33:31] == 3'b000 || alu_sum[33:31] == 3'b111) begin
      alu_sat = alu_sum[31:0];
    end else if (alu_sum[33]) begin
      alu_sat = cbfqs_pkg::CREDIT_MIN;
    end else begin
      alu_sat = cbfqs_pkg::CREDIT_MAX;
    end
    alu_gt = !alu_sum[33] && (alu_sum != '0);
  end

  // Ring arithmetic for the tail and the next head.
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic [PTR_W:0]   head_inc;
  logic [PTR_W-1:0] head_adv;
  logic             can_enq;

  always_comb begin
    tail_sum = {1'b0, head_cur} + {1'b0, occ_cur[PTR_W-1:0]};
    if (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    tail     = tail_sum[PTR_W-1:0];
    head_inc = {1'b0, head_cur} + (PTR_W+1)'(1);
    head_adv = (head_inc == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : head_inc[PTR_W-1:0];
    can_enq  = (CMP_W'(occ_cur) < CMP_W'(queue_limit)) &&
               (occ_cur != OCC_W'(QUEUE_DEPTH));
  end

  // Packet store.
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_base;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [23:0]       ram_rdata;

  assign ram_base  = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH);
  assign ram_waddr = ram_base + ADDR_W'(tail);
  assign ram_raddr = ram_base + ADDR_W'(head_cur);
  assign ram_we    = (state == cbfqs_pkg::S_CREDIT) && can_enq;
  assign ram_re    = (state == cbfqs_pkg::S_READ);

  cbfqs_ram #(
    .WIDTH(24),
    .DEPTH(NUM_QUEUES * QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({cur_size, cur_flow}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Handshake signals.
  logic in_take;
  logic out_free;
  logic any_busy;
  logic last_idx;

  assign in_stall = (state != cbfqs_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_idx = (idx == QW'(NUM_QUEUES - 1));

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      any_busy = any_busy || (occ[i] != '0);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cbfqs_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = (in_item.opcode == cbfqs_pkg::OP_DRAIN) ?
                       cbfqs_pkg::S_DSCAN : cbfqs_pkg::S_QUOT;
        end
      end
      cbfqs_pkg::S_QUOT:   state_next = cbfqs_pkg::S_REM;
      cbfqs_pkg::S_REM:    state_next = cbfqs_pkg::S_CREDIT;
      cbfqs_pkg::S_CREDIT: state_next = cbfqs_pkg::S_SCAN;
      cbfqs_pkg::S_SCAN: begin
        if (last_idx) begin
          state_next = (found || (occ_cur != '0 && alu_gt)) ?
                       cbfqs_pkg::S_READ : cbfqs_pkg::S_DONE;
        end
      end
      cbfqs_pkg::S_DSCAN: begin
        if (occ_cur != '0) begin
          state_next = cbfqs_pkg::S_READ;
        end else if (last_idx) begin
          state_next = cbfqs_pkg::S_DONE;
        end
      end
      cbfqs_pkg::S_READ: state_next = cbfqs_pkg::S_DONE;
      cbfqs_pkg::S_DONE: begin
        if (out_free) begin
          state_next = cbfqs_pkg::S_IDLE;
        end
      end
      default: state_next = cbfqs_pkg::S_IDLE;
    endcase
  end

  // Control state, per-queue state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cbfqs_pkg::S_IDLE;
      out_valid    <= 1'b0;
      credit_gain  <= cbfqs_pkg::CREDIT_GAIN_RST;
      service_cost <= cbfqs_pkg::SERVICE_COST_RST;
      queue_limit  <= cbfqs_pkg::QUEUE_LIMIT_RST;
      idx          <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]   <= '0;
        occ[i]    <= '0;
        credit[i] <= '0;
      end
    end else begin
      state <= state_next;

      // Register writes.
      if (cfg_write) begin
        unique case (cfg_index)
          cbfqs_pkg::CFG_CREDIT_GAIN:  credit_gain  <= cfg_data[15:0];
          cbfqs_pkg::CFG_SERVICE_COST: service_cost <= cfg_data;
          cbfqs_pkg::CFG_QUEUE_LIMIT:  queue_limit  <= cfg_data[5:0];
          default: ;
        endcase
      end

      // Output register.
      if (state == cbfqs_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Index and queue updates per step.
      unique case (state)
        cbfqs_pkg::S_IDLE: begin
          if (in_take) begin
            idx <= '0;
          end
        end
        cbfqs_pkg::S_REM: begin
          idx <= QW'(12'(cur_flow) - 12'(quot) * 12'(NUM_QUEUES));
        end
        cbfqs_pkg::S_CREDIT: begin
          credit[idx] <= alu_sat[31] ? 32'sd0 : alu_sat;
          if (can_enq) begin
            occ[idx] <= occ_cur + OCC_W'(1);
          end
          idx <= '0;
        end
        cbfqs_pkg::S_SCAN: begin
          if (last_idx) begin
            idx <= (occ_cur != '0 && alu_gt) ? idx : best;
          end else begin
            idx <= idx + QW'(1);
          end
        end
        cbfqs_pkg::S_DSCAN: begin
          if (occ_cur == '0 && !last_idx) begin
            idx <= idx + QW'(1);
          end
        end
        cbfqs_pkg::S_READ: begin
          credit[idx] <= alu_sat;
          head[idx]   <= head_adv;
          occ[idx]    <= occ_cur - OCC_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    unique case (state)
      cbfqs_pkg::S_IDLE: begin
        if (in_take) begin
          cur_opcode   <= in_item.opcode;
          cur_size     <= in_item.packet_size;
          cur_flow     <= in_item.flow_number;
          res_accepted <= 1'b0;
          res_served   <= 1'b0;
          res_credit   <= '0;
        end
      end
      cbfqs_pkg::S_QUOT: begin
        quot <= 8'((25'(cur_flow) * 25'(RECIP)) >> 16);
      end
      cbfqs_pkg::S_CREDIT: begin
        res_accepted <= can_enq;
        found        <= 1'b0;
        best         <= '0;
        best_credit  <= cbfqs_pkg::SERVE_FLOOR;
      end
      cbfqs_pkg::S_SCAN: begin
        if (occ_cur != '0 && alu_gt) begin
          found       <= 1'b1;
          best        <= idx;
          best_credit <= credit_cur;
        end
      end
      cbfqs_pkg::S_READ: begin
        res_served <= 1'b1;
        res_credit <= alu_sat;
      end
      cbfqs_pkg::S_DONE: begin
        if (out_free) begin
          out_item.accepted      <= res_accepted && (cur_opcode == cbfqs_pkg::OP_ARRIVE);
          out_item.served_valid  <= res_served;
          out_item.served_queue  <= res_served ? 3'(idx) : 3'd0;
          out_item.served_size   <= res_served ? ram_rdata[23:8] : 16'd0;
          out_item.served_flow   <= res_served ? ram_rdata[7:0] : 8'd0;
          out_item.served_credit <= res_served ? res_credit : 32'sd0;
          out_item.all_empty     <= !any_busy;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // The queue index never leaves the configured range.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= QW'(NUM_QUEUES - 1))
    else $error("queue index out of range");

  // A queue never holds more packets than its ring.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ_cur <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // Once an item is taken, the block is busy in the following cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("block ready right after taking an item");

  // A result with nothing served carries zero service fields.
  a_no_serve_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.served_valid) |->
      (out_item.served_credit == 32'sd0 && out_item.served_size == 16'd0))
    else $error("service fields set without a served packet");

  // The sequencer waits while a stalled result still fills the register.
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == cbfqs_pkg::S_DONE && out_valid && out_stall) |=>
      (state == cbfqs_pkg::S_DONE))
    else $error("result register overwritten while stalled");
`endif

endmodule

// ===== bench/tb_sched_pkg.sv =====
// ----------------------------------------------------------------------------
// tb_sched_pkg: scoreboard for the fair queue scheduler bench
// Holds a cycle-free copy of the scheduler state (credits, packet rings and
// registers). It works out the result item for each accepted input item,
// queues it, and compares every result item from the block with it.
// ----------------------------------------------------------------------------
package tb_sched_pkg;
  import cbfqs_pkg::*;

  localparam int NQ    = NUM_QUEUES_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;

  class sched_scoreboard;
    logic [15:0] credit_gain;
    logic [23:0] service_cost;
    logic [5:0]  queue_limit;
    logic [15:0] ring_size [NQ][DEPTH];
    logic [7:0]  ring_flow [NQ][DEPTH];
    int unsigned ring_head [NQ];
    int unsigned ring_fill [NQ];
    longint      credit [NQ];
    out_item_t   expected_results [$];
    int          mismatches;
    int          result_count;

    function new();
      credit_gain  = CREDIT_GAIN_RST;
      service_cost = SERVICE_COST_RST;
      queue_limit  = QUEUE_LIMIT_RST;
      for (int q = 0; q < NQ; q++) begin
        ring_head[q] = 0;
        ring_fill[q] = 0;
        credit[q]    = 0;
        for (int e = 0; e < DEPTH; e++) begin
          ring_size[q][e] = '0;
          ring_flow[q][e] = '0;
        end
      end
      mismatches   = 0;
      result_count = 0;
    endfunction

    // Mirror a register write on the configuration port.
    function void set_register(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_CREDIT_GAIN:  credit_gain  = data[15:0];
        CFG_SERVICE_COST: service_cost = data;
        CFG_QUEUE_LIMIT:  queue_limit  = data[5:0];
        default: ;
      endcase
    endfunction

    // Saturate a credit sum to the signed 32-bit range.
    function longint clamp32(longint v);
      if (v > longint'(CREDIT_MAX)) return longint'(CREDIT_MAX);
      if (v < longint'(CREDIT_MIN)) return longint'(CREDIT_MIN);
      return v;
    endfunction

    // Dequeue the head packet of a queue and charge the service cost.
    function void serve_queue(int q, inout out_item_t r);
      int unsigned h;
      h = ring_head[q];
      r.served_valid = 1'b1;
      r.served_queue = q[2:0];
      r.served_size  = ring_size[q][h];
      r.served_flow  = ring_flow[q][h];
      ring_head[q]   = (h + 1 >= DEPTH) ? 0 : h + 1;
      ring_fill[q]   = ring_fill[q] - 1;
      credit[q]      = clamp32(credit[q] - longint'(service_cost));
      r.served_credit = credit[q][31:0];
    endfunction

    // Work out the result item that one input item causes.
    function out_item_t predict_service(in_item_t it);
      out_item_t   r;
      int          q;
      int          best;
      longint      best_credit;
      longint      c;
      int unsigned lim;
      int unsigned tail;
      r = '0;
      if (it.opcode == OP_ARRIVE) begin
        q   = it.flow_number % NQ;
        lim = (queue_limit < DEPTH) ? queue_limit : DEPTH;
        // Weighted credit gain; a negative credit is raised to zero.
        c = clamp32(credit[q] + longint'(q + 1) * longint'(credit_gain));
        if (c < 0) c = 0;
        credit[q] = c;
        if (ring_fill[q] < lim) begin
          tail = (ring_head[q] + ring_fill[q]) % DEPTH;
          ring_size[q][tail] = it.packet_size;
          ring_flow[q][tail] = it.flow_number;
          ring_fill[q] = ring_fill[q] + 1;
          r.accepted = 1'b1;
        end
        // Highest credit above the floor wins, the lowest index on a tie.
        best        = -1;
        best_credit = longint'(SERVE_FLOOR);
        for (int j = 0; j < NQ; j++) begin
          if (ring_fill[j] > 0 && credit[j] > best_credit) begin
            best_credit = credit[j];
            best        = j;
          end
        end
        if (best >= 0) serve_queue(best, r);
      end else begin
        // A drain serves the lowest non-empty queue whatever its credit.
        for (int j = 0; j < NQ; j++) begin
          if (ring_fill[j] > 0) begin
            serve_queue(j, r);
            break;
          end
        end
      end
      r.all_empty = 1'b1;
      for (int j = 0; j < NQ; j++) begin
        if (ring_fill[j] != 0) r.all_empty = 1'b0;
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      expected_results.push_back(predict_service(it));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Print one line for the mismatch and count it.
    task report_mismatch(string what, longint got, longint want);
      $display("result %0d: %s got %0d, expected %0d", result_count, what, got, want);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing waiting, served_queue", got.served_queue, 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", got.accepted, want.accepted);
      if (got.served_valid !== want.served_valid)
        report_mismatch("served_valid", got.served_valid, want.served_valid);
      if (got.served_queue !== want.served_queue)
        report_mismatch("served_queue", got.served_queue, want.served_queue);
      if (got.served_size !== want.served_size)
        report_mismatch("served_size", got.served_size, want.served_size);
      if (got.served_flow !== want.served_flow)
        report_mismatch("served_flow", got.served_flow, want.served_flow);
      if (got.served_credit !== want.served_credit)
        report_mismatch("served_credit", longint'(got.served_credit),
                        longint'(want.served_credit));
      if (got.all_empty !== want.all_empty)
        report_mismatch("all_empty", got.all_empty, want.all_empty);
    endtask
  endclass

endpackage

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: bench for credit_based_fair_queue_scheduler_core
// Drives a directed set of items and then random segments under changing
// register settings and handshake idling, including long receiver
// hold-offs. Every result item is checked against the scoreboard's
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import cbfqs_pkg::*;
  import tb_sched_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = NUM_QUEUES_DEF + 10;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_CREDIT_GAIN;
  logic [23:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  sched_scoreboard sb;

  credit_based_fair_queue_scheduler_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off counted here when asked for.
  always @(posedge clk) begin
    if (hold_seen != hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_request;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: note accepted input items and check accepted result items.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // Offer one item after a random gap and hold it until it is accepted.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(logic op, logic [15:0] size, logic [7:0] flow);
    in_item_t it;
    it.opcode      = op;
    it.packet_size = size;
    it.flow_number = flow;
    send_item(it);
  endtask

  function automatic in_item_t random_item(int drain_pct);
    in_item_t it;
    it.opcode      = ($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_ARRIVE;
    it.packet_size = $urandom_range(16'hFFFF);
    it.flow_number = $urandom_range(255);
    return it;
  endfunction

  // Stop offering and wait until every expected result item has come.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers while the block is idle.
  task automatic write_regs(logic [15:0] gain, logic [23:0] cost, logic [5:0] limit);
    cfg_write <= 1'b1;
    cfg_index <= CFG_CREDIT_GAIN;
    cfg_data  <= {8'd0, gain};
    @(posedge clk);
    cfg_index <= CFG_SERVICE_COST;
    cfg_data  <= cost;
    @(posedge clk);
    cfg_index <= CFG_QUEUE_LIMIT;
    cfg_data  <= {18'd0, limit};
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    sb.set_register(CFG_CREDIT_GAIN, {8'd0, gain});
    sb.set_register(CFG_SERVICE_COST, cost);
    sb.set_register(CFG_QUEUE_LIMIT, {18'd0, limit});
  endtask

  initial begin
    logic [15:0] gain;
    logic [23:0] cost;
    logic [5:0]  limit;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, nothing to serve, field extremes.
    send_fields(OP_DRAIN, 16'h0000, 8'h00);
    send_fields(OP_ARRIVE, 16'h0000, 8'h00);
    send_fields(OP_ARRIVE, 16'hFFFF, 8'hFF);
    send_fields(OP_ARRIVE, 16'h5A5A, 8'h04);
    send_fields(OP_ARRIVE, 16'hA5A5, 8'h05);
    send_fields(OP_DRAIN, 16'hFFFF, 8'hFF);
    wait_idle();

    // A zero limit drops every arrival.
    write_regs(16'd66, 24'd65536, 6'd0);
    send_fields(OP_ARRIVE, 16'h1234, 8'h03);
    send_fields(OP_ARRIVE, 16'h4321, 8'h08);
    send_fields(OP_DRAIN, 16'h0001, 8'h01);
    wait_idle();

    // Limit above the depth, largest gain and no cost.
    write_regs(16'hFFFF, 24'd0, 6'd63);
    send_fields(OP_ARRIVE, 16'h00FF, 8'h04);
    send_fields(OP_ARRIVE, 16'hFF00, 8'h09);
    send_fields(OP_ARRIVE, 16'h8000, 8'h03);
    wait_idle();

    // No gain and the largest cost: credits go negative and are raised again.
    write_regs(16'd0, 24'hFFFFFF, 6'd32);
    send_fields(OP_ARRIVE, 16'h0F0F, 8'h02);
    send_fields(OP_ARRIVE, 16'hF0F0, 8'h07);
    send_fields(OP_ARRIVE, 16'h3C3C, 8'h0C);
    send_fields(OP_DRAIN, 16'h0000, 8'h00);
    wait_idle();

    // Cost just over one credit, single-entry queues.
    write_regs(16'd1, 24'd65537, 6'd1);
    send_fields(OP_ARRIVE, 16'h7FFF, 8'h01);
    send_fields(OP_ARRIVE, 16'h0002, 8'h06);
    send_fields(OP_ARRIVE, 16'hC3C3, 8'h80);
    wait_idle();

    // Random segments under changing settings and idling.
    for (int seg = 0; seg < 10; seg++) begin
      case ($urandom_range(3))
        0:       gain = 16'd0;
        1:       gain = 16'hFFFF;
        2:       gain = $urandom_range(255);
        default: gain = $urandom_range(16'hFFFF);
      endcase
      case ($urandom_range(3))
        0:       cost = 24'd0;
        1:       cost = 24'hFFFFFF;
        2:       cost = 24'd65536;
        default: cost = $urandom_range(24'hFFFFFF);
      endcase
      case ($urandom_range(7))
        0:       limit = 6'd0;
        1:       limit = 6'd1;
        2:       limit = 6'd32;
        3:       limit = 6'd63;
        default: limit = $urandom_range(63, 1);
      endcase
      write_regs(gain, cost, limit);
      if (seg < 4) begin
        send_idle_pct  = 10;
        recv_stall_pct = 85;
      end else if (seg < 7) begin
        send_idle_pct  = 85;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // The receiver holds off while items keep coming, so the block backs up.
      if (seg == 2 || seg == 8) hold_request++;
      repeat (100) send_item(random_item(20));
      wait_idle();
    end

    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(4_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cbfqs_pkg.sv
hdl/cbfqs_ram.sv
hdl/credit_based_fair_queue_scheduler_core.sv
bench/tb_sched_pkg.sv
bench/tb_top.sv
